FILE: sv/pmrs_pkg.sv
`timescale 1ns / 1ps

package pmrs_pkg;

	localparam int ADDR_W     = 3;
	localparam int RAW_W      = 16;
	localparam int OUT_W      = 45;
	localparam int LSB_W      = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	// multiplier operands and rounding terms
	localparam int A_W     = 21;
	localparam int B_W     = LSB_W;
	localparam int P_W     = A_W + B_W;
	localparam int C_W     = 12;
	localparam int SH_W    = 2;

	// divide by 1000 through a reciprocal, exact for numerators below 2^40
	localparam int X_W       = 40;
	localparam int XH_W      = X_W / 2;
	localparam int RECIP_W   = 41;
	localparam int KL_W      = 21;
	localparam int KH_W      = RECIP_W - KL_W;
	localparam int RECIP_SH  = 50;
	localparam int Q_W       = 30;
	localparam logic [RECIP_W-1:0] RECIP_K = 41'd1125899906843;

	localparam logic [LSB_W-1:0] LSB_RESET = 24'd1000;
	localparam logic [OUT_W-1:0] OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};

	localparam int SHUNT_MUL     = 10;
	localparam int ROUND_HALF    = 500;
	localparam int SHUNT_HALF_B  = 2000;
	localparam int SHUNT_SH_B    = 2;
	localparam int BUS_SH_A      = 3;
	localparam int BUS_LSB_A     = 4000;
	localparam int BUS_LSB_B     = 1250;
	localparam int PWR_FACTOR_A  = 20;
	localparam int PWR_FACTOR_B  = 25;

	typedef enum logic [ADDR_W-1:0] {
		ADDR_NONE    = 3'd0,
		ADDR_SHUNT   = 3'd1,
		ADDR_BUS     = 3'd2,
		ADDR_POWER   = 3'd3,
		ADDR_CURRENT = 3'd4,
		ADDR_RAW_A   = 3'd5,
		ADDR_RAW_B   = 3'd6,
		ADDR_RAW_C   = 3'd7
	} reg_addr_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHIP_VARIANT = 1'b0,
		CFG_CURRENT_LSB  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic rnd;
		logic neg;
		logic bad;
	} side_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} div_en_t;

endpackage

FILE: sv/pmrs_if.sv
`timescale 1ns / 1ps

interface pmrs_in_if;
	import pmrs_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] reg_address;
	logic [RAW_W-1:0]  raw_value;

	modport source(output valid, reg_address, raw_value, input ready);
	modport sink(input valid, reg_address, raw_value, output ready);
endinterface

interface pmrs_out_if;
	import pmrs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] scaled_value;
	logic                    bad_address;

	modport source(output valid, scaled_value, bad_address, input ready);
	modport sink(input valid, scaled_value, bad_address, output ready);
endinterface

FILE: sv/pmrs_div1000.sv
`timescale 1ns / 1ps

module pmrs_div1000 (
	input  logic                           clk,
	input  pmrs_pkg::div_en_t              en,
	input  logic [pmrs_pkg::X_W-1:0]       x,
	output logic [pmrs_pkg::Q_W-1:0]       q
);
	import pmrs_pkg::*;

	localparam logic [KH_W-1:0] K_HI = RECIP_K[RECIP_W-1:KL_W];
	localparam logic [KL_W-1:0] K_LO = RECIP_K[KL_W-1:0];
	localparam int HH_W = XH_W + KH_W;
	localparam int HL_W = XH_W + KL_W;
	localparam int CR_W = HL_W + 1;
	localparam int T_W  = X_W + RECIP_W;

	logic [HH_W-1:0] pp_hh_s4, pp_lh_s4;
	logic [HL_W-1:0] pp_hl_s4, pp_ll_s4;
	logic [HH_W-1:0] pp_hh_s5;
	logic [HL_W-1:0] pp_ll_s5;
	logic [CR_W-1:0] cross_s5;
	logic [T_W-1:0]  total;

	// partial products of x times the reciprocal
	always_ff @(posedge clk) begin
		if (en.s4) begin
			pp_hh_s4 <= HH_W'(x[X_W-1:XH_W]) * HH_W'(K_HI);
			pp_hl_s4 <= HL_W'(x[X_W-1:XH_W]) * HL_W'(K_LO);
			pp_lh_s4 <= HH_W'(x[XH_W-1:0]) * HH_W'(K_HI);
			pp_ll_s4 <= HL_W'(x[XH_W-1:0]) * HL_W'(K_LO);
		end
	end

	// the two middle terms line up once the low-by-high one moves left a bit
	always_ff @(posedge clk) begin
		if (en.s5) begin
			pp_hh_s5 <= pp_hh_s4;
			pp_ll_s5 <= pp_ll_s4;
			cross_s5 <= CR_W'(pp_hl_s4) + CR_W'({pp_lh_s4, 1'b0});
		end
	end

	assign total = {pp_hh_s5, {(T_W-HH_W){1'b0}}}
		+ {{(T_W-CR_W-XH_W){1'b0}}, cross_s5, {XH_W{1'b0}}}
		+ {{(T_W-HL_W){1'b0}}, pp_ll_s5};

	always_ff @(posedge clk) begin
		if (en.s6) begin
			q <= total[RECIP_SH +: Q_W];
		end
	end

endmodule

FILE: sv/power_monitor_reading_scaler.sv
`timescale 1ns / 1ps

// channel   dir   modport      payload
// reading   in    pmrs_in_if   reg_address[2:0], raw_value[15:0]
// result    out   pmrs_out_if  scaled_value[44:0] signed, bad_address
// cfg       in    plain write  cfg_we, cfg_index[0:0], cfg_data[23:0]
//
// seven register stages, one word in per cycle while result is not stalled
// the single 21x24 multiplier and the split reciprocal multiply that divides
// by 1000 are both fully pipelined
// each stage takes a new word when it is empty or the one after it moves, so
// a stall on result fills the bubbles before reading.ready drops
// reset clears valid bits and configuration (variant 0, current step 1000 uA)

module power_monitor_reading_scaler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pmrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pmrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	pmrs_in_if.sink                           reading,
	pmrs_out_if.source                        result
);
	import pmrs_pkg::*;

	localparam int STAGES = 7;

	logic             variant_q;
	logic [LSB_W-1:0] lsb_q;

	logic [STAGES:1] vld;
	logic [STAGES:1] rdy;

	// stage 1 inputs
	logic [RAW_W-1:0] mag;
	logic [A_W-1:0]   a_d;
	logic [B_W-1:0]   b_d;
	logic [C_W-1:0]   c_d;
	logic [SH_W-1:0]  k_d;
	side_t            side_d;

	logic [A_W-1:0]   a_s1;
	logic [B_W-1:0]   b_s1;
	logic [C_W-1:0]   c_s1, c_s2;
	logic [SH_W-1:0]  k_s1, k_s2;
	logic [P_W-1:0]   p_s2;
	logic [P_W:0]     n_s2;
	logic [OUT_W-1:0] val_s3, val_s4, val_s5, val_s6;
	side_t            side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic [Q_W-1:0]   q_s6;
	div_en_t          div_en;
	logic [OUT_W-1:0] mag_q;

	logic signed [OUT_W-1:0] scaled_s7;
	logic                    bad_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
			lsb_q     <= LSB_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHIP_VARIANT: variant_q <= cfg_data[0];
				CFG_CURRENT_LSB:  lsb_q     <= cfg_data[LSB_W-1:0];
				default: ;
			endcase
		end
	end

	// stall chain: a stage loads when it is empty or its word moves on
	always_comb begin
		rdy[STAGES] = !vld[STAGES] || result.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
	end

	assign reading.ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) vld[1] <= reading.valid;
			for (int k = 2; k <= STAGES; k++) begin
				if (rdy[k]) vld[k] <= vld[k-1];
			end
		end
	end

	// every conversion becomes floor(((a*b + c) >> k) / 1000), or a*b clamped to OUT_MAX
	always_comb begin
		mag    = reading.raw_value[RAW_W-1] ? RAW_W'(~reading.raw_value + 16'd1)
			: reading.raw_value;
		a_d    = '0;
		b_d    = '0;
		c_d    = C_W'(ROUND_HALF);
		k_d    = '0;
		side_d = '{rnd: 1'b0, neg: 1'b0, bad: 1'b0};
		case (reg_addr_t'(reading.reg_address))
			ADDR_SHUNT: begin
				a_d        = A_W'(mag);
				b_d        = B_W'(SHUNT_MUL);
				c_d        = variant_q ? C_W'(SHUNT_HALF_B) : C_W'(ROUND_HALF);
				k_d        = variant_q ? SH_W'(SHUNT_SH_B) : '0;
				side_d.rnd = 1'b1;
				side_d.neg = reading.raw_value[RAW_W-1];
			end
			ADDR_BUS: begin
				a_d        = variant_q ? A_W'(reading.raw_value)
					: A_W'(reading.raw_value >> BUS_SH_A);
				b_d        = variant_q ? B_W'(BUS_LSB_B) : B_W'(BUS_LSB_A);
				side_d.rnd = 1'b1;
			end
			ADDR_POWER: begin
				a_d = A_W'(reading.raw_value)
					* (variant_q ? A_W'(PWR_FACTOR_B) : A_W'(PWR_FACTOR_A));
				b_d = lsb_q;
			end
			ADDR_CURRENT: begin
				a_d        = A_W'(mag);
				b_d        = lsb_q;
				side_d.rnd = 1'b1;
				side_d.neg = reading.raw_value[RAW_W-1];
			end
			ADDR_RAW_A, ADDR_RAW_B, ADDR_RAW_C: begin
				a_d = A_W'(reading.raw_value);
				b_d = B_W'(1);
			end
			default: begin
				side_d.bad = 1'b1;
			end
		endcase
	end

	assign n_s2 = (P_W+1)'(p_s2) + (P_W+1)'(c_s2);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			a_s1    <= a_d;
			b_s1    <= b_d;
			c_s1    <= c_d;
			k_s1    <= k_d;
			side_s1 <= side_d;
		end
		if (rdy[2]) begin
			p_s2    <= a_s1 * b_s1;
			c_s2    <= c_s1;
			k_s2    <= k_s1;
			side_s2 <= side_s1;
		end
		if (rdy[3]) begin
			if (side_s2.rnd) begin
				val_s3 <= OUT_W'(n_s2 >> k_s2);
			end else begin
				val_s3 <= (p_s2 > OUT_MAX) ? OUT_MAX : p_s2;
			end
			side_s3 <= side_s2;
		end
		if (rdy[4]) begin
			val_s4  <= val_s3;
			side_s4 <= side_s3;
		end
		if (rdy[5]) begin
			val_s5  <= val_s4;
			side_s5 <= side_s4;
		end
		if (rdy[6]) begin
			val_s6  <= val_s5;
			side_s6 <= side_s5;
		end
		if (rdy[7]) begin
			if (side_s6.rnd) begin
				scaled_s7 <= side_s6.neg ? -$signed(mag_q) : $signed(mag_q);
			end else begin
				scaled_s7 <= $signed(val_s6);
			end
			bad_s7 <= side_s6.bad;
		end
	end

	assign div_en = '{s4: rdy[4], s5: rdy[5], s6: rdy[6]};
	assign mag_q  = OUT_W'(q_s6);

	pmrs_div1000 u_div (
		.clk (clk),
		.en  (div_en),
		.x   (val_s3[X_W-1:0]),
		.q   (q_s6)
	);

	assign result.valid        = vld[STAGES];
	assign result.scaled_value = scaled_s7;
	assign result.bad_address  = bad_s7;

endmodule

FILE: sv/pmrs_checker.sv
`timescale 1ns / 1ps

module pmrs_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [pmrs_pkg::OUT_W-1:0]     scaled_value,
	input logic                                  bad_address
);
	import pmrs_pkg::*;

	localparam logic signed [OUT_W-1:0] OUT_MIN = -45'sd549755781;

	// an empty output stage means every stage can load
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_address |-> scaled_value == '0)
		else $error("unconverted address with nonzero value");

	a_lower_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> scaled_value >= OUT_MIN)
		else $error("scaled word below the signed current floor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scaled_value)
			&& $stable(bad_address))
		else $error("result word changed while stalled");

endmodule

bind power_monitor_reading_scaler pmrs_checker u_pmrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (reading.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.scaled_value (result.scaled_value),
	.bad_address  (result.bad_address)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import pmrs_pkg::*;

	localparam int ITEMS        = 950;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_PROBES     = 18;
	localparam int N_PHASES     = 12;
	localparam int SETTLE       = 10;
	localparam int LONG_HOLD    = 300;
	localparam int MAX_REPORTS  = 10;
	localparam longint SAT_MAX  = (longint'(1) << (OUT_W - 1)) - 1;

	// scaling constants of the two chip variants
	localparam longint DIV_SHUNT_A = 100;
	localparam longint DIV_SHUNT_B = 400;
	localparam longint STEP_BUS_A  = 4000;
	localparam longint STEP_BUS_B  = 1250;
	localparam longint PWR_MUL_A   = 20;
	localparam longint PWR_MUL_B   = 25;
	localparam longint MILLI       = 1000;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    bad;
	} result_word_t;

	typedef struct {
		reg_addr_t   addr;
		logic [15:0] raw;
		bit          typed;
		longint      val;
		logic        bad;
	} probe_t;

	typedef struct {
		logic        variant;
		logic [23:0] lsb;
		int          gap_max;
		int          stall_pct;
	} phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pmrs_in_if  reading_ch();
	pmrs_out_if result_ch();

	power_monitor_reading_scaler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.reading(reading_ch),
		.result(result_ch)
	);

	// mirror of the configuration registers
	logic        cur_variant;
	logic [23:0] cur_lsb;

	result_word_t pending_scaled[$];
	int mismatch_count;
	int results_checked;
	int readings_sent;
	int settings_used;
	int burst_left;
	int gap_max;
	int stall_pct;
	bit long_hold_req;
	int cycle_count;

	probe_t probes[N_PROBES];
	phase_t phases[N_PHASES];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_half_away(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic result_word_t scale_reading(reg_addr_t addr, logic [15:0] raw);
		result_word_t w;
		longint v;
		longint s;
		logic [15:0] bus_raw;
		s = longint'($signed(raw));
		v = 0;
		w.bad = 1'b0;
		case (addr)
			ADDR_SHUNT: begin
				v = round_half_away(s, cur_variant ? DIV_SHUNT_B : DIV_SHUNT_A);
			end
			ADDR_BUS: begin
				bus_raw = cur_variant ? raw : (raw >> BUS_SH_A);
				v = round_half_away(longint'(bus_raw) * (cur_variant ? STEP_BUS_B : STEP_BUS_A),
					MILLI);
			end
			ADDR_POWER: begin
				v = longint'(raw) * (cur_variant ? PWR_MUL_B : PWR_MUL_A) * longint'(cur_lsb);
				if (v > SAT_MAX)
					v = SAT_MAX;
			end
			ADDR_CURRENT: begin
				v = round_half_away(s * longint'(cur_lsb), MILLI);
			end
			ADDR_RAW_A, ADDR_RAW_B, ADDR_RAW_C: begin
				v = longint'(raw);
			end
			default: begin
				v = 0;
				w.bad = 1'b1;
			end
		endcase
		w.value = v[OUT_W-1:0];
		return w;
	endfunction

	function automatic logic [15:0] pick_raw();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			// small signed values land on the rounding halves
			3, 4: return 16'($urandom_range(0, 1200) - 600);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CHIP_VARIANT)
			cur_variant = data[0];
		else
			cur_lsb = data[23:0];
		@(negedge clk);
	endtask

	// offer one word, in bursts with random gaps; returns at the falling edge after acceptance
	task automatic offer(reg_addr_t addr, logic [15:0] raw, bit typed, result_word_t typed_word);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				reading_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		reading_ch.valid       <= 1'b1;
		reading_ch.reg_address <= addr;
		reading_ch.raw_value   <= raw;
		do @(posedge clk); while (!reading_ch.ready);
		pending_scaled.push_back(typed ? typed_word : scale_reading(addr, raw));
		readings_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		reading_ch.valid <= 1'b0;
		while (pending_scaled.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// result side: stalls of its own, plus one long hold-off on request
	initial begin
		int hold_left;
		int run_left;
		hold_left = 0;
		run_left = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				result_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				run_left = $urandom_range(0, 4);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_word_t got;
		result_word_t want;
		if (result_ch.valid && result_ch.ready) begin
			got.value = result_ch.scaled_value;
			got.bad   = result_ch.bad_address;
			if (pending_scaled.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected word: value %0d bad %0b", got.value, got.bad);
			end else begin
				want = pending_scaled.pop_front();
				results_checked++;
				if (got.value !== want.value || got.bad !== want.bad) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("word %0d: expected value %0d bad %0b, got value %0d bad %0b",
							results_checked, want.value, want.bad, got.value, got.bad);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
			pending_scaled.size());
		$display("power_monitor_reading_scaler: mismatch");
		$finish;
	end

	initial begin
		int per_phase;
		result_word_t tw;
		reading_ch.valid       = 1'b0;
		reading_ch.reg_address = '0;
		reading_ch.raw_value   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		cur_variant = 1'b0;
		cur_lsb     = 24'd1000;
		mismatch_count  = 0;
		results_checked = 0;
		readings_sent   = 0;
		settings_used   = 1;
		burst_left      = 0;
		gap_max         = 3;
		stall_pct       = 20;
		long_hold_req   = 1'b0;

		// reset settings: variant 0, current step 1000 uA
		probes = '{
			'{ADDR_NONE,    16'h0000, 1, 0,          1'b1},
			'{ADDR_NONE,    16'hFFFF, 1, 0,          1'b1},
			'{ADDR_SHUNT,   16'h0000, 1, 0,          1'b0},
			'{ADDR_SHUNT,   16'h7FFF, 1, 328,        1'b0},
			'{ADDR_SHUNT,   16'h8000, 1, -328,       1'b0},
			'{ADDR_SHUNT,   16'h0032, 0, 0,          1'b0},
			'{ADDR_SHUNT,   16'hFFCE, 0, 0,          1'b0},
			'{ADDR_BUS,     16'h0000, 1, 0,          1'b0},
			'{ADDR_BUS,     16'hFFFF, 1, 32764,      1'b0},
			'{ADDR_BUS,     16'h0008, 0, 0,          1'b0},
			'{ADDR_POWER,   16'h0000, 1, 0,          1'b0},
			'{ADDR_POWER,   16'hFFFF, 1, 1310700000, 1'b0},
			'{ADDR_CURRENT, 16'h7FFF, 1, 32767,      1'b0},
			'{ADDR_CURRENT, 16'h8000, 1, -32768,     1'b0},
			'{ADDR_CURRENT, 16'h0001, 0, 0,          1'b0},
			'{ADDR_RAW_A,   16'h0000, 1, 0,          1'b0},
			'{ADDR_RAW_B,   16'hFFFF, 1, 65535,      1'b0},
			'{ADDR_RAW_C,   16'hA5A5, 1, 42405,      1'b0}
		};

		// variant, current step, sender gap, receiver stall percent
		phases = '{
			'{1'b1, 24'd1000,     3, 20},
			'{1'b0, 24'd500,      0, 0},
			'{1'b1, 24'd1500,     0, 10},
			'{1'b0, 24'd0,        5, 40},
			'{1'b1, 24'd0,        2, 60},
			'{1'b0, 24'd1,        4, 25},
			'{1'b1, 24'd1,        1, 0},
			'{1'b1, 24'd10000000, 6, 30},
			'{1'b0, 24'd10000000, 0, 50},
			'{1'b1, 24'd16777215, 3, 15},
			'{1'b0, 24'd16777215, 8, 70},
			'{1'b0, 24'd0,        2, 5}
		};
		phases[N_PHASES-1].lsb = 24'($urandom_range(1, 10000000));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probes[i]) begin
			tw.value = probes[i].val[OUT_W-1:0];
			tw.bad   = probes[i].bad;
			offer(probes[i].addr, probes[i].raw, probes[i].typed, tw);
		end
		drain();

		per_phase = (ITEMS - N_PROBES) / N_PHASES;
		foreach (phases[p]) begin
			write_reg(CFG_CHIP_VARIANT, CFG_DATA_W'(phases[p].variant));
			write_reg(CFG_CURRENT_LSB, phases[p].lsb);
			settings_used++;
			gap_max   = phases[p].gap_max;
			stall_pct = phases[p].stall_pct;
			burst_left = 0;
			// hold the result side long enough for the block to back up onto its input
			if (p == 2)
				long_hold_req = 1'b1;
			repeat (per_phase)
				offer(reg_addr_t'($urandom_range(0, 7)), pick_raw(), 1'b0, '0);
			drain();
		end

		if (pending_scaled.size() != 0) begin
			mismatch_count += pending_scaled.size();
			$display("%0d expected words never arrived", pending_scaled.size());
		end

		$display("sent %0d readings across all register addresses under %0d scaling settings",
			readings_sent, settings_used);
		$display("checked %0d result words, %0d failures", results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("power_monitor_reading_scaler: match");
		else
			$display("power_monitor_reading_scaler: mismatch");
		$finish;
	end

endmodule
